// ===== design/sfrg_pkg.sv =====
package sfrg_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned OUT_W      = 31;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned FACTOR_W   = 7;
    localparam int unsigned RAD_W      = 40;
    localparam int unsigned ROOT_STEPS = RAD_W / 2 + VALUE_W;
    localparam int unsigned ROOT_W     = ROOT_STEPS;
    localparam int unsigned REM_W      = ROOT_W + 2;
    localparam int unsigned CNT_W      = $clog2(ROOT_STEPS);

    localparam logic [FACTOR_W-1:0] ROOT_FACTOR  = FACTOR_W'(100);
    localparam logic [VALUE_W-1:0]  RESTORE_CODE = VALUE_W'(1);
    localparam logic [CNT_W-1:0]    LAST_STEP    = CNT_W'(ROOT_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ROOT  = 3'b010,
        S_SCALE = 3'b100
    } t_state;

endpackage

// ===== design/sqrt_fraction_random_generator.sv =====
// A load transaction (mode 0) gives no result. A next transaction (mode 1) stalls the input
// until it is done: on accept the state, or the time seed if the state is zero, is multiplied
// by 100; the bit-serial square-root unit shifts in one radicand bit pair and settles one root
// bit per cycle; the scale step waits for the output to be free, then scales the 32-bit
// fraction by 2147483647 into the output register. The result waits in that register while
// the output is stalled, and a new input transaction may be taken meanwhile.
module sqrt_fraction_random_generator
    import sfrg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic [VALUE_W-1:0] i_seed_value,
    input  logic [VALUE_W-1:0] i_time_seed,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [OUT_W-1:0]  o_random_value,
    output logic [BYTE_W-1:0] o_random_byte
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_cur, n_cur;
    logic [VALUE_W-1:0] r_saved, n_saved;
    logic [RAD_W-1:0]   r_rad;
    logic [ROOT_W-1:0]  r_root;
    logic [REM_W-1:0]   r_rem;
    logic [OUT_W-1:0]   r_value;

    logic               w_accept;
    logic               w_do_load;
    logic [VALUE_W-1:0] w_seed;
    logic [VALUE_W-1:0] w_loaded_cur;
    logic [RAD_W-2:0]   w_rad;
    logic [REM_W+1:0]   w_rem_sh;
    logic [REM_W+1:0]   w_trial;
    logic [REM_W+1:0]   w_diff;
    logic               w_ge;
    logic               w_out_free;
    logic [2*VALUE_W-2:0] w_scaled;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_random_value = r_value;
    assign o_random_byte  = r_value[BYTE_W-1:0];

    assign w_seed    = i_mode ? i_time_seed : i_seed_value;
    assign w_do_load = !i_mode || (r_cur == '0);
    assign w_loaded_cur = (w_seed == RESTORE_CODE && r_saved != '0) ? r_saved : w_seed;
    assign w_rad = {{FACTOR_W{1'b0}}, n_cur} * {{VALUE_W{1'b0}}, ROOT_FACTOR};

    assign w_rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;

    assign w_scaled = {r_root[VALUE_W-1:0], {(VALUE_W-1){1'b0}}}
                    - {{(VALUE_W-1){1'b0}}, r_root[VALUE_W-1:0]};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_cur       = r_cur;
        n_saved     = r_saved;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_do_load) begin
                        n_cur = w_loaded_cur;
                        if (!(w_seed == RESTORE_CODE && r_saved != '0)) begin
                            n_saved = w_seed;
                        end
                    end
                    if (i_mode) begin
                        n_state = S_ROOT;
                        n_cnt   = '0;
                    end
                end
            end
            S_ROOT: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_cur       = {1'b0, w_scaled[2*VALUE_W-2:VALUE_W]};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            r_saved     <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            r_saved     <= n_saved;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept && i_mode) begin
            r_rad  <= {1'b0, w_rad};
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_state == S_ROOT) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
        end
        if (r_state == S_SCALE && w_out_free) begin
            r_value <= w_scaled[2*VALUE_W-2:VALUE_W];
        end
    end

`ifndef NO_ASSERTIONS
    a_next_starts_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && w_accept && i_mode) |=> (r_state == S_ROOT && r_cnt == '0))
        else $error("Next transaction did not start the root unit.");

    a_result_from_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_SCALE))
        else $error("Result appeared outside the scale step.");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT || r_state == S_SCALE) |-> (r_rem <= {1'b0, r_root, 1'b0}))
        else $error("Root remainder exceeds twice the partial root.");

    a_state_matches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE && w_out_free)
            |=> (r_cur == {1'b0, o_random_value} && o_out_valid))
        else $error("Stored value differs from the delivered result.");
`endif

endmodule

// ===== test/sqrt_fraction_random_generator_tb.sv =====
`timescale 1ns / 1ps

module sqrt_fraction_random_generator_tb;
    import sfrg_pkg::*;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_NEXT = 1'b1;
    localparam logic [63:0] SQRT_GAIN = 64'd100;
    localparam logic [63:0] SPREAD = 64'd2147483647;
    localparam int RANDOM_ITEMS = 750;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic              mode;
        logic [VALUE_W-1:0] seed;
        logic [VALUE_W-1:0] tseed;
        bit                quiet;
    } t_gen_item;

    typedef struct {
        logic [OUT_W-1:0]  value;
        logic [BYTE_W-1:0] lsb;
        bit                quiet;
    } t_gen_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_mode = 1'b0;
    logic [VALUE_W-1:0] i_seed_value = '0;
    logic [VALUE_W-1:0] i_time_seed = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [OUT_W-1:0]  o_random_value;
    logic [BYTE_W-1:0] o_random_byte;

    t_gen_item   pending_items[$];
    t_gen_result expected_results[$];
    t_gen_item   drv_item;

    logic [VALUE_W-1:0] gen_value = '0;
    logic [VALUE_W-1:0] kept_seed = '0;

    int n_items;
    int n_accepted = 0;
    int n_loads = 0;
    int n_nexts = 0;
    int n_checked = 0;
    int n_errors = 0;
    int idle_cnt = 0;
    int hold_cnt = 0;
    int cycle_count = 0;

    sqrt_fraction_random_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_seed_value   (i_seed_value),
        .i_time_seed    (i_time_seed),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_random_value (o_random_value),
        .o_random_byte  (o_random_byte)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] scaled_root(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        logic [1:0]  pair;
        rem = '0;
        root = '0;
        for (int i = 51; i >= 0; i--) begin
            pair = (i >= 32) ? n[2*(i-32) +: 2] : 2'b00;
            rem = {rem[61:0], pair};
            trial = {root[61:0], 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                root = {root[62:0], 1'b1};
            end else begin
                root = {root[62:0], 1'b0};
            end
        end
        return root;
    endfunction

    task automatic apply_seed(input logic [VALUE_W-1:0] s);
        if (s == RESTORE_CODE && kept_seed != '0) begin
            gen_value = kept_seed;
        end else begin
            gen_value = s;
            kept_seed = s;
        end
    endtask

    task automatic predict_item(input t_gen_item it);
        logic [63:0]        root;
        logic [63:0]        prod;
        logic [VALUE_W-1:0] frac;
        t_gen_result        res;
        if (it.mode == MODE_LOAD) begin
            apply_seed(it.seed);
            n_loads++;
        end else begin
            if (gen_value == '0) begin
                apply_seed(it.tseed);
            end
            root = scaled_root({32'd0, gen_value} * SQRT_GAIN);
            frac = root[31:0];
            prod = {32'd0, frac} * SPREAD;
            gen_value = prod[63:32];
            res.value = gen_value[OUT_W-1:0];
            res.lsb = gen_value[BYTE_W-1:0];
            res.quiet = it.quiet;
            expected_results.push_back(res);
            n_nexts++;
        end
    endtask

    task automatic add_item(input logic m, input logic [VALUE_W-1:0] s,
                            input logic [VALUE_W-1:0] t);
        t_gen_item it;
        it.mode = m;
        it.seed = s;
        it.tseed = t;
        it.quiet = ((pending_items.size() / 64) % 4) == 3;
        pending_items.push_back(it);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            idle_cnt = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_item(drv_item);
                n_accepted++;
                idle_cnt = drv_item.quiet ? 0 : $urandom_range(0, 15);
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (idle_cnt != 0 || pending_items.size() == 0) begin
                    if (idle_cnt != 0) begin
                        idle_cnt--;
                    end
                    i_in_valid <= 1'b0;
                    i_mode <= 1'($urandom_range(0, 1));
                    i_seed_value <= $urandom;
                    i_time_seed <= $urandom;
                end else begin
                    drv_item = pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    i_mode <= drv_item.mode;
                    i_seed_value <= drv_item.seed;
                    i_time_seed <= drv_item.tseed;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_gen_result exp_res;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, got value %0d byte %0d",
                             $time, o_random_value, o_random_byte);
                end else begin
                    exp_res = expected_results.pop_front();
                    n_checked++;
                    if (o_random_value !== exp_res.value) begin
                        n_errors++;
                        $display("%0t: random_value mismatch, expected %0d, got %0d",
                                 $time, exp_res.value, o_random_value);
                    end
                    if (o_random_byte !== exp_res.lsb) begin
                        n_errors++;
                        $display("%0t: random_byte mismatch, expected %0d, got %0d",
                                 $time, exp_res.lsb, o_random_byte);
                    end
                end
                if (expected_results.size() != 0 && expected_results[0].quiet) begin
                    hold_cnt = 0;
                end else begin
                    hold_cnt = $urandom_range(0, 15);
                end
            end else if (o_out_valid && hold_cnt != 0) begin
                hold_cnt--;
            end
            i_out_stall <= (hold_cnt != 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [VALUE_W-1:0] s;
        logic [VALUE_W-1:0] t;
        int pick;

        // The root of zero keeps a zero state at zero.
        add_item(MODE_NEXT, '0, '0);
        add_item(MODE_NEXT, '1, '0);
        // A restore request with nothing saved behaves as an ordinary load.
        add_item(MODE_LOAD, 32'd1, '1);
        add_item(MODE_NEXT, '0, '1);
        add_item(MODE_LOAD, '1, '0);
        add_item(MODE_NEXT, '0, '0);
        add_item(MODE_NEXT, '1, '1);
        add_item(MODE_LOAD, 32'd1, '0);
        add_item(MODE_NEXT, '0, '0);
        // A zero state reseeds from the time field.
        add_item(MODE_LOAD, '0, '0);
        add_item(MODE_NEXT, '0, '1);
        add_item(MODE_LOAD, '0, '0);
        add_item(MODE_NEXT, '0, 32'd1);
        add_item(MODE_LOAD, 32'h8000_0000, '0);
        add_item(MODE_NEXT, '0, '0);
        add_item(MODE_LOAD, 32'h7FFF_FFFF, '1);
        add_item(MODE_NEXT, '1, '0);
        add_item(MODE_LOAD, 32'd2, '0);
        add_item(MODE_NEXT, '0, '0);
        add_item(MODE_LOAD, 32'd1, '0);
        add_item(MODE_NEXT, '0, '0);
        add_item(MODE_LOAD, '0, '0);
        add_item(MODE_LOAD, 32'd1, '0);
        add_item(MODE_NEXT, '0, '0);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       s = '0;
                1:       s = 32'd1;
                2:       s = $urandom_range(2, 255);
                3:       s = '1 - $urandom_range(0, 15);
                default: s = $urandom;
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       t = '0;
                1:       t = 32'd1;
                default: t = $urandom;
            endcase
            if ($urandom_range(0, 99) < 25) begin
                add_item(MODE_LOAD, s, t);
            end else begin
                add_item(MODE_NEXT, s, t);
            end
        end
        n_items = pending_items.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (n_accepted != n_items) @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);

        $display("Ran %0d input transactions: %0d seed loads and %0d next-value requests.",
                 n_accepted, n_loads, n_nexts);
        $display("Checked %0d results in %0d cycles with random stalls on both sides.",
                 n_checked, cycle_count);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
